/* design/gbp_pkg.sv */
// Shared types and constants for the gshare branch predictor.
package gbp_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam int HIST_LEN_W = 4;
    localparam int CTR_W      = 3;

    localparam logic [REG_IDX_W-1:0]  REG_HISTORY_BITS = 1'b0;
    localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET   = 4'd8;

    localparam logic [CTR_W-1:0] CTR_INIT = 3'd4;
    localparam logic [CTR_W-1:0] CTR_MAX  = 3'd7;
    localparam logic [CTR_W-1:0] CTR_MIN  = 3'd0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } gbp_state_t;

endpackage

/* design/gbp_if.sv */
// Valid/ready channels for resolved branches and prediction results.
interface gbp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] branch_address;
    logic        taken;

    modport source (output valid, output branch_address, output taken, input ready);
    modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface gbp_out_if;
    logic valid;
    logic ready;
    logic predicted_taken;
    logic mispredicted;

    modport source (output valid, output predicted_taken, output mispredicted, input ready);
    modport sink   (input valid, input predicted_taken, input mispredicted, output ready);
endinterface

/* design/gshare_branch_predictor_core.sv */
// Gshare branch predictor with 3-bit saturating counters: top level.
// After reset the counter table is swept to weakly taken, one entry per cycle; no branch
// is accepted during the sweep, configuration writes are. For each branch the counter table
// is read in the accept cycle (registered synchronous read) and written back with the
// saturated counter in the next, while the history register shifts. The result sits in an
// output register; the next branch is accepted only once that result is taken, at the
// earliest in the same cycle. The history length register lies at byte address 0 of the
// APB port.
module gshare_branch_predictor_core #(
    parameter int INDEX_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    gbp_in_if.sink                           branch,
    gbp_out_if.source                        result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gbp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gbp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import gbp_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [CTR_W-1:0] ctr_mem [DEPTH];

    gbp_state_t              state_reg, state_next;
    logic [INDEX_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [INDEX_BITS-1:0]   hist_reg, hist_next;
    logic [HIST_LEN_W-1:0]   hist_len_reg, hist_len_next;
    logic                    out_valid_reg, out_valid_next;
    logic [INDEX_BITS-1:0]   idx_reg;
    logic                    taken_reg;
    logic [CTR_W-1:0]        rd_data_reg;
    logic                    pred_reg;
    logic                    misp_reg;

    logic [INDEX_BITS-1:0]   hist_mask;
    logic [INDEX_BITS-1:0]   hist_top;
    logic [INDEX_BITS-1:0]   idx_next;
    logic                    accept;
    logic                    wr_en;
    logic [INDEX_BITS-1:0]   wr_addr;
    logic [CTR_W-1:0]        wr_data;
    logic [CTR_W-1:0]        ctr_upd;
    logic                    cfg_wr;
    logic [REG_IDX_W-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb
    begin
        case (reg_idx)
            REG_HISTORY_BITS: prdata = {{(APB_DATA_W-HIST_LEN_W){1'b0}}, hist_len_reg};
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < INDEX_BITS; i++)
        begin
            hist_mask[i] = (i < int'(hist_len_reg));
        end
    end

    assign hist_top = hist_mask & ~(hist_mask >> 1);
    assign idx_next = branch.branch_address[INDEX_BITS+1:2] ^ (hist_reg & hist_mask);
    assign accept   = branch.valid & branch.ready;

    always_comb
    begin
        if (taken_reg)
        begin
            ctr_upd = (rd_data_reg == CTR_MAX) ? rd_data_reg : rd_data_reg + 3'd1;
        end
        else
        begin
            ctr_upd = (rd_data_reg == CTR_MIN) ? rd_data_reg : rd_data_reg - 3'd1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        hist_next      = hist_reg;
        out_valid_next = out_valid_reg & ~result.ready;
        branch.ready   = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = ctr_upd;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = CTR_INIT;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                branch.ready = ~out_valid_reg | result.ready;
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                wr_en          = 1'b1;
                out_valid_next = 1'b1;
                hist_next      = (((hist_reg & hist_mask) >> 1)
                                 | (taken_reg ? hist_top : '0)) & hist_mask;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign hist_len_next = (cfg_wr && reg_idx == REG_HISTORY_BITS)
                         ? pwdata[HIST_LEN_W-1:0] : hist_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            hist_reg      <= '0;
            hist_len_reg  <= HIST_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            hist_reg      <= hist_next;
            hist_len_reg  <= hist_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= idx_next;
            taken_reg <= branch.taken;
        end
        if (state_reg == ST_UPDATE)
        begin
            pred_reg <= rd_data_reg[CTR_W-1];
            misp_reg <= rd_data_reg[CTR_W-1] ^ taken_reg;
        end
    end

    // Counter table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ctr_mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= ctr_mem[idx_next];
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.predicted_taken = pred_reg;
    assign result.mispredicted    = misp_reg;

endmodule

/* verif/tb_gshare_branch_predictor_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the gshare branch predictor core with its own prediction ledger.
module tb_gshare_branch_predictor_core;
    import gbp_pkg::*;

    localparam int INDEX_BITS    = 10;
    localparam int TABLE_DEPTH   = 1 << INDEX_BITS;
    localparam int MAX_GAP       = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 128;
    localparam int POOL_SIZE     = 8;
    localparam int NUM_PHASES    = 12;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED    = 1'b1;
    localparam logic [CTR_W-1:0]     TAKEN_THRESHOLD = CTR_INIT;

    localparam logic [HIST_LEN_W-1:0] PHASE_LENS [NUM_PHASES] = '{
        4'd10, 4'd0, 4'd15, 4'd1, 4'd8, 4'd12, 4'd5, 4'd10, 4'd3, 4'd9, 4'd7, 4'd14
    };

    typedef struct packed {
        logic predicted_taken;
        logic mispredicted;
    } verdict_t;

    class prediction_ledger;
        logic [CTR_W-1:0]      counters [TABLE_DEPTH];
        logic [INDEX_BITS-1:0] history;
        logic [HIST_LEN_W-1:0] hist_len;
        verdict_t              awaited [$];
        int                    mismatches;

        function new();
            foreach (counters[i])
                counters[i] = CTR_INIT;
            history    = '0;
            hist_len   = HIST_LEN_RESET;
            mismatches = 0;
        endfunction

        function void set_hist_len(logic [HIST_LEN_W-1:0] len);
            hist_len = len;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            if (mismatches < REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        endfunction

        function void record_branch(logic [31:0] addr, logic outcome);
            int unsigned           len;
            logic [INDEX_BITS-1:0] mask;
            logic [INDEX_BITS-1:0] hist;
            logic [INDEX_BITS-1:0] idx;
            logic [CTR_W-1:0]      ctr;
            verdict_t              verdict;
            len  = (hist_len > INDEX_BITS) ? INDEX_BITS : hist_len;
            mask = INDEX_BITS'((1 << len) - 1);
            hist = history & mask;
            idx  = addr[INDEX_BITS+1:2] ^ hist;
            ctr  = counters[idx];
            verdict.predicted_taken = (ctr >= TAKEN_THRESHOLD);
            verdict.mispredicted    = verdict.predicted_taken ^ outcome;
            awaited.push_back(verdict);
            if (outcome && ctr != CTR_MAX)
                ctr++;
            else if (!outcome && ctr != CTR_MIN)
                ctr--;
            counters[idx] = ctr;
            hist = hist >> 1;
            if (outcome && len > 0)
                hist[len-1] = 1'b1;
            history = hist & mask;
        endfunction

        function void check_result(logic predicted_taken, logic mispredicted);
            verdict_t want;
            if (awaited.size() == 0)
            begin
                flag("unexpected result", '0, 32'({predicted_taken, mispredicted}));
                return;
            end
            want = awaited.pop_front();
            if (predicted_taken !== want.predicted_taken)
                flag("predicted_taken", 32'(want.predicted_taken), 32'(predicted_taken));
            if (mispredicted !== want.mispredicted)
                flag("mispredicted", 32'(want.mispredicted), 32'(mispredicted));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit                    burst_mode;
    bit                    hold_request;
    int                    idle_cycles = 0;
    prediction_ledger      ledger;

    gbp_in_if  branch_ch ();
    gbp_out_if result_ch ();

    gshare_branch_predictor_core #(
        .INDEX_BITS(INDEX_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .branch (branch_ch),
        .result (result_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                ledger.check_result(result_ch.predicted_taken, result_ch.mispredicted);
            if (branch_ch.valid && branch_ch.ready)
                ledger.record_branch(branch_ch.branch_address, branch_ch.taken);
        end
    end

    always @(posedge clk)
    begin
        if ((branch_ch.valid && branch_ch.ready) || (result_ch.valid && result_ch.ready)
            || (psel && penable && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result receiver: random back-pressure, one long hold-off on request
    initial
    begin
        int gap;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request    = 1'b0;
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                result_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    task automatic send_branch(input logic [31:0] addr, input logic outcome);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            branch_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        branch_ch.valid          = 1'b1;
        branch_ch.branch_address = addr;
        branch_ch.taken          = outcome;
        do @(posedge clk); while (!branch_ch.ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        branch_ch.valid = 1'b0;
        while (ledger.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (write && idx == REG_HISTORY_BITS)
            ledger.set_hist_len(wdata[HIST_LEN_W-1:0]);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_history_len();
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b0, REG_HISTORY_BITS, '0, rdata);
        if (rdata[HIST_LEN_W-1:0] !== ledger.hist_len)
            ledger.flag("history_bits readback", 32'(ledger.hist_len),
                        32'(rdata[HIST_LEN_W-1:0]));
    endtask

    task automatic set_history_len(input logic [HIST_LEN_W-1:0] len);
        logic [APB_DATA_W-1:0] wdata;
        logic [APB_DATA_W-1:0] rdata;
        wdata                   = $urandom();
        wdata[HIST_LEN_W-1:0]   = len;
        apb_access(1'b1, REG_HISTORY_BITS, wdata, rdata);
        check_history_len();
    endtask

    // biased branches from a small address pool, mixed with fully random ones
    task automatic run_branches(input int count);
        logic [31:0] pool [POOL_SIZE];
        int unsigned bias [POOL_SIZE];
        int          pick;
        logic [31:0] addr;
        logic        outcome;
        foreach (pool[i])
        begin
            pool[i] = $urandom();
            bias[i] = $urandom_range(0, 4) * 25;
        end
        repeat (count)
        begin
            pick = $urandom_range(0, POOL_SIZE + 2);
            if (pick < POOL_SIZE)
            begin
                addr    = pool[pick];
                outcome = ($urandom_range(0, 99) < bias[pick]);
            end
            else
            begin
                addr    = $urandom();
                outcome = 1'($urandom_range(0, 1));
            end
            send_branch(addr, outcome);
        end
    endtask

    initial
    begin
        logic [APB_DATA_W-1:0] rdata;
        ledger                   = new();
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        branch_ch.valid          = 1'b0;
        branch_ch.branch_address = '0;
        branch_ch.taken          = 1'b0;
        burst_mode               = 1'b0;
        hold_request             = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        check_history_len();
        send_branch(32'h0000_0000, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b0);
        send_branch(32'hAAAA_AAAA, 1'b1);
        send_branch(32'h5555_5555, 1'b0);
        drain_results();

        // no history: drive one counter to the top, then all the way down
        set_history_len(4'd0);
        repeat (5) send_branch(32'h0000_0100, 1'b1);
        repeat (9) send_branch(32'h0000_0100, 1'b0);
        drain_results();

        // length beyond the index width
        set_history_len(4'd15);
        send_branch(32'h0000_0FFC, 1'b1);
        send_branch(32'h0000_0FFC, 1'b1);
        send_branch(32'hFFFF_F000, 1'b0);
        send_branch(32'h8000_0003, 1'b1);
        drain_results();

        apb_access(1'b1, REG_UNMAPPED, '1, rdata);
        check_history_len();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            burst_mode = (p == 5);
            set_history_len(PHASE_LENS[p]);
            if (p == 3)
                hold_request = 1'b1;
            run_branches(PHASE_ITEMS / 2);
            if (p == 7)
                drain_results();
            run_branches(PHASE_ITEMS / 2);
        end

        drain_results();
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* gshare_branch_predictor_core.f */
design/gbp_pkg.sv
design/gbp_if.sv
design/gshare_branch_predictor_core.sv
verif/tb_gshare_branch_predictor_core.sv
